// File: src/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types, port offsets and command codes for the paged RAM disk port.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int PRD_MEM_BYTES = 524288;
    // full store address: port B bits 2..0, port A, counter
    localparam int PRD_ADDR_FULL_W = 19;

    // port offsets
    localparam logic [7:0] OFF_RD_A    = 8'h48;
    localparam logic [7:0] OFF_RD_B    = 8'h4A;
    localparam logic [7:0] OFF_RD_C    = 8'h4C;
    localparam logic [7:0] OFF_RD_MODE = 8'h4E;
    localparam logic [7:0] OFF_WR_A    = 8'h58;
    localparam logic [7:0] OFF_WR_B    = 8'h5A;
    localparam logic [7:0] OFF_WR_C    = 8'h5C;
    localparam logic [7:0] OFF_WR_CTRL = 8'h5E;
    localparam logic [7:0] OFF_DATA0   = 8'h68;
    localparam logic [7:0] OFF_DATA1   = 8'h69;
    localparam logic [7:0] OFF_DATA2   = 8'h78;
    localparam logic [7:0] OFF_DATA3   = 8'h79;
    localparam logic [7:0] OFF_RA_LO   = 8'h48;
    localparam logic [7:0] OFF_RA_HI   = 8'h4E;
    localparam logic [7:0] OFF_WA_LO   = 8'h58;
    localparam logic [7:0] OFF_WA_HI   = 8'h5E;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [7:0] NO_RAM_BYTE = 8'hFF;
    localparam int BANK_BITS      = 3;
    localparam int CLR_CNT_BIT    = 5;
    localparam int MODE_SET_BIT   = 7;

    // command codes from front to back
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_RD_A    = 4'd1;
    localparam logic [OP_W-1:0] OP_RD_B    = 4'd2;
    localparam logic [OP_W-1:0] OP_RD_C    = 4'd3;
    localparam logic [OP_W-1:0] OP_RD_MODE = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_DATA = 4'd5;
    localparam logic [OP_W-1:0] OP_WR_A    = 4'd6;
    localparam logic [OP_W-1:0] OP_WR_B    = 4'd7;
    localparam logic [OP_W-1:0] OP_WR_C    = 4'd8;
    localparam logic [OP_W-1:0] OP_WR_CTRL = 4'd9;
    localparam logic [OP_W-1:0] OP_WR_DATA = 4'd10;

    typedef struct packed {
        logic       func;
        logic [7:0] offset;
        logic [7:0] wdata;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       claimed;
    } t_out;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            claimed;
        logic [7:0]      wdata;
    } t_cmd;

endpackage

// File: src/paged_ram_disk_port.sv
// ----------------------------------------------------------------------------
// paged_ram_disk_port
// Bus-side port registers and paged byte store behind a queue interface.
// ----------------------------------------------------------------------------
// path: command queue, then result queue; data reads add the registered store read
// throughput: one word per cycle while the result queue has room; after a data
//   read the back end takes no command until its store read is queued
// reset: ports, mode word, counter and queues clear, ram_present sets to 1;
//   store contents are kept and undefined until written
module paged_ram_disk_port
    import prd_pkg::*;
#(
    parameter int MEM_BYTES = PRD_MEM_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_in,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_out,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic cmd_valid;
    logic cmd_take;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    prd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    prd_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out       (o_out)
    );

endmodule

// File: src/prd_front.sv
// ----------------------------------------------------------------------------
// prd_front
// Decodes each bus word into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module prd_front
    import prd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_in  i_in,
    output logic o_full,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_cmd       n_cmd;
    logic       push;
    logic       data_port;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_push && !o_full;

    always_comb begin
        data_port = (i_in.offset == OFF_DATA0) || (i_in.offset == OFF_DATA1) ||
                    (i_in.offset == OFF_DATA2) || (i_in.offset == OFF_DATA3);
        n_cmd.wdata   = i_in.wdata;
        n_cmd.claimed = data_port ||
                        ((i_in.offset >= OFF_RA_LO) && (i_in.offset <= OFF_RA_HI)) ||
                        ((i_in.offset >= OFF_WA_LO) && (i_in.offset <= OFF_WA_HI));
        n_cmd.op = OP_NONE;
        if (i_in.func == FUNC_READ) begin
            case (i_in.offset)
                OFF_RD_A:    n_cmd.op = OP_RD_A;
                OFF_RD_B:    n_cmd.op = OP_RD_B;
                OFF_RD_C:    n_cmd.op = OP_RD_C;
                OFF_RD_MODE: n_cmd.op = OP_RD_MODE;
                default:     n_cmd.op = data_port ? OP_RD_DATA : OP_NONE;
            endcase
        end else begin
            case (i_in.offset)
                OFF_WR_A:    n_cmd.op = OP_WR_A;
                OFF_WR_B:    n_cmd.op = OP_WR_B;
                OFF_WR_C:    n_cmd.op = OP_WR_C;
                OFF_WR_CTRL: n_cmd.op = OP_WR_CTRL;
                default:     n_cmd.op = data_port ? OP_WR_DATA : OP_NONE;
            endcase
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_cmd_take) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_cmd_take) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

endmodule

// File: src/prd_back.sv
// ----------------------------------------------------------------------------
// prd_back
// Carries out commands: port registers, counter, byte store, result queue.
// ----------------------------------------------------------------------------
module prd_back
    import prd_pkg::*;
#(
    parameter int MEM_BYTES = PRD_MEM_BYTES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_take,
    input  logic i_cfg_valid,
    input  logic i_cfg_data,
    input  logic i_pop,
    output logic o_empty,
    output t_out o_out
);

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_MEM  = 1'b1;

    logic       r_state;
    logic       r_ram_present;
    logic [7:0] r_page;
    logic [7:0] r_bank;
    logic [7:0] r_port_c;
    logic [7:0] r_mode;
    logic [7:0] r_counter;
    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rd_data;

    t_out       r_oq [2];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;
    logic [1:0] n_ocnt;

    logic [PRD_ADDR_FULL_W-1:0] full_addr;
    logic [AW-1:0]              addr;
    logic       mem_rd;
    logic       mem_wr;
    logic       out_push;
    logic       out_pop;
    t_out       n_out;

    assign full_addr = {r_bank[BANK_BITS-1:0], r_page, r_counter};
    // store size is a power of two, so the modulo is a mask
    assign addr = full_addr[AW-1:0];

    assign o_cmd_take = i_cmd_valid && (r_state == S_IDLE) && (r_ocnt != 2'd2);
    assign mem_rd  = o_cmd_take && (i_cmd.op == OP_RD_DATA) && r_ram_present;
    assign mem_wr  = o_cmd_take && (i_cmd.op == OP_WR_DATA) && r_ram_present;
    assign out_pop = i_pop && !o_empty;
    assign out_push = (r_state == S_MEM) || (o_cmd_take && !mem_rd);
    assign o_empty = (r_ocnt == 2'd0);
    assign o_out   = r_oq[r_orp];

    always_comb begin
        n_out.claimed = i_cmd.claimed;
        n_out.rdata   = 8'h00;
        if (r_state == S_MEM) begin
            n_out.claimed = 1'b1;
            n_out.rdata   = r_rd_data;
        end else begin
            case (i_cmd.op)
                OP_RD_A:    n_out.rdata = r_page;
                OP_RD_B:    n_out.rdata = r_bank;
                OP_RD_C:    n_out.rdata = r_port_c;
                OP_RD_MODE: n_out.rdata = r_mode;
                OP_RD_DATA: n_out.rdata = NO_RAM_BYTE;
                default:    n_out.rdata = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_ocnt = r_ocnt;
        if (out_push && !out_pop) begin
            n_ocnt = r_ocnt + 2'd1;
        end else if (!out_push && out_pop) begin
            n_ocnt = r_ocnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ram_present <= 1'b1;
            r_page        <= 8'h00;
            r_bank        <= 8'h00;
            r_port_c      <= 8'h00;
            r_mode        <= 8'h00;
            r_counter     <= 8'h00;
            r_owp         <= 1'b0;
            r_orp         <= 1'b0;
            r_ocnt        <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_ram_present <= i_cfg_data;
            end
            r_ocnt <= n_ocnt;
            if (out_push) begin
                r_owp <= ~r_owp;
            end
            if (out_pop) begin
                r_orp <= ~r_orp;
            end
            r_state <= mem_rd ? S_MEM : S_IDLE;
            if (mem_rd || mem_wr) begin
                r_counter <= r_counter + 8'd1;
            end
            if (o_cmd_take) begin
                case (i_cmd.op)
                    OP_WR_A: r_page <= i_cmd.wdata;
                    OP_WR_B: begin
                        r_bank <= i_cmd.wdata;
                        if (i_cmd.wdata[CLR_CNT_BIT]) begin
                            r_counter <= 8'h00;
                        end
                    end
                    OP_WR_C: r_port_c <= i_cmd.wdata;
                    OP_WR_CTRL: begin
                        if (i_cmd.wdata[MODE_SET_BIT]) begin
                            // mode set clears ports and counter
                            r_mode    <= i_cmd.wdata;
                            r_page    <= 8'h00;
                            r_bank    <= 8'h00;
                            r_port_c  <= 8'h00;
                            r_counter <= 8'h00;
                        end else begin
                            r_port_c[i_cmd.wdata[3:1]] <= i_cmd.wdata[0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[addr] <= i_cmd.wdata;
        end
        if (mem_rd) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_oq[r_owp] <= n_out;
        end
    end

endmodule

// File: tb/sv/tb_paged_ram_disk_port.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_paged_ram_disk_port
// Self-checking bench for the paged RAM disk port. Accesses are generated in
// six phases, alternating the ram_present setting, with random push and pop
// gaps. Each accepted access is run through a behavioral port and store
// model. Every result word is compared against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_paged_ram_disk_port;
    import prd_pkg::*;

    localparam logic [7:0] CNT_CLR_MASK = 8'(1 << CLR_CNT_BIT);
    localparam int PHASES = 6;

    typedef struct packed {
        logic [7:0] page;
        logic [7:0] bank;
        logic [7:0] port_c;
        logic [7:0] mode;
        logic [7:0] counter;
    } t_disk_regs;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    t_in  i_in = '0;
    logic o_full;
    logic i_pop = 1'b0;
    logic o_empty;
    t_out o_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    t_in        access_q[$];
    t_out       resp_due_q[$];
    logic [7:0] disk_img[int];
    // store entries that the generated sequence has already written
    bit         plan_written[int];
    t_disk_regs live_regs = '0;
    t_disk_regs plan_regs = '0;
    logic       live_ram = 1'b1;
    logic       plan_ram = 1'b1;
    logic       push_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt = 0;
    int word_cnt = 0;
    int access_cnt = 0;
    int phase_items = 0;
    int store_rd_cnt = 0;
    int store_wr_cnt = 0;
    int wrap_cnt = 0;

    paged_ram_disk_port dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // one bus access against the port registers; the caller owns the store
    function automatic void disk_port_step(inout t_disk_regs r, input t_in acc,
                                           input logic ram_on, output t_out res,
                                           output logic store_rd,
                                           output logic store_wr,
                                           output int addr);
        logic data_port;
        data_port = acc.offset == OFF_DATA0 || acc.offset == OFF_DATA1 ||
                    acc.offset == OFF_DATA2 || acc.offset == OFF_DATA3;
        res = '0;
        store_rd = 1'b0;
        store_wr = 1'b0;
        addr = int'({r.bank[BANK_BITS-1:0], r.page, r.counter}) % PRD_MEM_BYTES;
        res.claimed = (acc.offset >= OFF_RA_LO && acc.offset <= OFF_RA_HI) ||
                      (acc.offset >= OFF_WA_LO && acc.offset <= OFF_WA_HI) ||
                      data_port;
        if (acc.func == FUNC_READ) begin
            case (acc.offset)
                OFF_RD_A:    res.rdata = r.page;
                OFF_RD_B:    res.rdata = r.bank;
                OFF_RD_C:    res.rdata = r.port_c;
                OFF_RD_MODE: res.rdata = r.mode;
                default: begin
                    if (data_port && ram_on) begin
                        store_rd = 1'b1;
                        r.counter = r.counter + 8'd1;
                    end else if (data_port) begin
                        res.rdata = NO_RAM_BYTE;
                    end
                end
            endcase
        end else begin
            case (acc.offset)
                OFF_WR_A: r.page = acc.wdata;
                OFF_WR_B: begin
                    r.bank = acc.wdata;
                    if (acc.wdata[CLR_CNT_BIT]) r.counter = '0;
                end
                OFF_WR_C: r.port_c = acc.wdata;
                OFF_WR_CTRL: begin
                    if (acc.wdata[MODE_SET_BIT]) begin
                        r.mode = acc.wdata;
                        r.page = '0;
                        r.bank = '0;
                        r.port_c = '0;
                        r.counter = '0;
                    end else begin
                        // bits 3..1 select the port C bit, bit 0 is its value
                        r.port_c[acc.wdata[3:1]] = acc.wdata[0];
                    end
                end
                default: begin
                    if (data_port && ram_on) begin
                        store_wr = 1'b1;
                        r.counter = r.counter + 8'd1;
                    end
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] pick_data_off();
        case ($urandom_range(0, 3))
            0: return OFF_DATA0;
            1: return OFF_DATA1;
            2: return OFF_DATA2;
            default: return OFF_DATA3;
        endcase
    endfunction

    // queue one access, keeping data reads on entries that were written
    task automatic plan_push(input logic func, input logic [7:0] off,
                             input logic [7:0] wd);
        t_in        acc;
        t_disk_regs nxt;
        t_out       res;
        logic       srd;
        logic       swr;
        int         addr;
        acc.func = func;
        acc.offset = off;
        acc.wdata = wd;
        nxt = plan_regs;
        disk_port_step(nxt, acc, plan_ram, res, srd, swr, addr);
        if (srd && !plan_written.exists(addr)) begin
            // fresh entry: write it instead of reading it
            acc.func = FUNC_WRITE;
            nxt = plan_regs;
            disk_port_step(nxt, acc, plan_ram, res, srd, swr, addr);
        end
        if (swr) plan_written[addr] = 1'b1;
        plan_regs = nxt;
        access_q.push_back(acc);
        phase_items++;
        access_cnt++;
    endtask

    // page and bank select, a burst of data writes with occasional port reads, counter rewind, read back
    task automatic run_burst();
        logic [7:0] bank;
        int n;
        int m;
        bank = 8'($urandom_range(0, 255));
        plan_push(FUNC_WRITE, OFF_WR_A, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            plan_push(FUNC_WRITE, OFF_WR_B, bank & ~CNT_CLR_MASK);
        else
            plan_push(FUNC_WRITE, OFF_WR_B, bank | CNT_CLR_MASK);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 20);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0)
                plan_push(FUNC_READ, OFF_RA_LO + 8'(2 * $urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            plan_push(FUNC_WRITE, pick_data_off(), 8'($urandom_range(0, 255)));
        end
        plan_push(FUNC_WRITE, OFF_WR_B, bank | CNT_CLR_MASK);
        m = $urandom_range(1, n);
        repeat (m) plan_push(FUNC_READ, pick_data_off(), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_noise();
        logic [7:0] off;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: off = 8'($urandom_range(OFF_RA_LO, OFF_RA_HI));
                1: off = 8'($urandom_range(OFF_WA_LO, OFF_WA_HI));
                2: off = pick_data_off();
                default: off = 8'($urandom_range(0, 255));
            endcase
            plan_push(1'($urandom_range(0, 1)), off, 8'($urandom_range(0, 255)));
        end
    endtask

    // sender: next word from the access queue, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (!i_push || push_taken) begin
            if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in <= access_q.pop_front();
                i_push <= 1'b1;
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_pop <= 1'b0;
        else
            i_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : predict_and_check
        t_out res;
        t_out due;
        logic srd;
        logic swr;
        int   addr;
        push_taken <= i_push && !o_full;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) live_ram = i_cfg_data;
            if (i_push && !o_full) begin
                disk_port_step(live_regs, i_in, live_ram, res, srd, swr, addr);
                if (srd) begin
                    res.rdata = disk_img[addr];
                    store_rd_cnt++;
                end
                if (swr) begin
                    disk_img[addr] = i_in.wdata;
                    store_wr_cnt++;
                end
                if ((srd || swr) && live_regs.counter == 8'd0) wrap_cnt++;
                resp_due_q.push_back(res);
            end
            if (i_pop && !o_empty) begin
                word_cnt++;
                if (resp_due_q.size() == 0) begin
                    $display("%0t: unexpected word, got rdata %02h claimed %0b",
                             $time, o_out.rdata, o_out.claimed);
                    err_cnt++;
                end else begin
                    due = resp_due_q.pop_front();
                    if (o_out.rdata !== due.rdata) begin
                        $display("%0t: rdata mismatch, expected %02h, got %02h",
                                 $time, due.rdata, o_out.rdata);
                        err_cnt++;
                    end
                    if (o_out.claimed !== due.claimed) begin
                        $display("%0t: claimed mismatch, expected %0b, got %0b",
                                 $time, due.claimed, o_out.claimed);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int ph;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        for (ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 45 : 0;
            recv_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 32 : 0;
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data <= (ph % 2 == 0);
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            plan_ram = (ph % 2 == 0);
            phase_items = 0;
            if (ph == 0) begin
                plan_push(FUNC_READ, OFF_RD_A, 8'hFF);
                plan_push(FUNC_READ, OFF_RD_MODE, 8'h00);
                plan_push(FUNC_WRITE, OFF_WR_A, 8'hFF);
                plan_push(FUNC_WRITE, OFF_WR_B, 8'h07);
                plan_push(FUNC_WRITE, OFF_DATA0, 8'h00);
                plan_push(FUNC_WRITE, OFF_DATA1, 8'hFF);
                plan_push(FUNC_WRITE, OFF_DATA2, 8'hA5);
                plan_push(FUNC_WRITE, OFF_DATA3, 8'h5A);
                // counter clear while keeping bank 7
                plan_push(FUNC_WRITE, OFF_WR_B, 8'h27);
                plan_push(FUNC_READ, OFF_DATA0, 8'h00);
                plan_push(FUNC_READ, OFF_DATA1, 8'h00);
                plan_push(FUNC_READ, OFF_DATA2, 8'h00);
                plan_push(FUNC_READ, OFF_DATA3, 8'h00);
                plan_push(FUNC_READ, OFF_RD_B, 8'h00);
                // port C bit set and clear
                plan_push(FUNC_WRITE, OFF_WR_CTRL, 8'h0F);
                plan_push(FUNC_WRITE, OFF_WR_CTRL, 8'h01);
                plan_push(FUNC_READ, OFF_RD_C, 8'h00);
                plan_push(FUNC_WRITE, OFF_WR_CTRL, 8'h0E);
                plan_push(FUNC_WRITE, OFF_WR_C, 8'hC3);
                // mode set wipes ports and counter
                plan_push(FUNC_WRITE, OFF_WR_CTRL, 8'h9B);
                plan_push(FUNC_READ, OFF_RD_MODE, 8'h00);
                plan_push(FUNC_READ, OFF_RD_C, 8'h00);
                // decoded but dead, then undecoded
                plan_push(FUNC_READ, 8'h49, 8'h00);
                plan_push(FUNC_READ, OFF_WR_B, 8'h00);
                plan_push(FUNC_WRITE, OFF_RD_A, 8'h77);
                plan_push(FUNC_READ, 8'hFF, 8'h00);
                plan_push(FUNC_WRITE, 8'h00, 8'hFF);
            end
            while (phase_items < (plan_ram ? 500 : 130)) begin
                if ($urandom_range(0, 3) != 0)
                    run_burst();
                else
                    run_noise();
            end
            while (access_q.size() != 0 || i_push || resp_due_q.size() != 0)
                @(posedge i_clk);
            repeat (6) @(posedge i_clk);
        end
        $display("ran %0d accesses over %0d phases with ram_present toggled per phase",
                 access_cnt, PHASES);
        $display("%0d words checked, %0d store writes, %0d store reads, %0d counter wraps",
                 word_cnt, store_wr_cnt, store_rd_cnt, wrap_cnt);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("timeout with %0d words still due", resp_due_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
